/* rtl/core/mec_pkg.sv */
// ----------------------------------------------------------------------------
// mec_pkg
// Shared widths, register indexes and reset values for the escape counter.
// ----------------------------------------------------------------------------
package mec_pkg;

  localparam int C_W       = 32;  // width of c and z parts
  localparam int PROD_W    = 64;  // full product width
  localparam int THR_W     = 35;  // escape threshold width
  localparam int LIM_W     = 16;  // iteration limit register width
  localparam int CNT_OUT_W = 16;  // step count port width
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ITERATION_LIMIT  = 2'd1;

  localparam logic [THR_W-1:0] THR_RESET = 35'd1073741824;
  localparam logic [LIM_W-1:0] LIM_RESET = 16'd255;

  localparam logic signed [PROD_W-1:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [PROD_W-1:0] SAT_MIN = -64'sd2147483648;

  typedef logic signed [C_W-1:0]    cpart_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  function automatic cpart_t sat_c(input prod_t v);
    cpart_t r;
    if (v > SAT_MAX) begin
      r = cpart_t'(SAT_MAX);
    end else if (v < SAT_MIN) begin
      r = cpart_t'(SAT_MIN);
    end else begin
      r = cpart_t'(v);
    end
    return r;
  endfunction

endpackage

/* rtl/core/mandelbrot_escape_counter_unit.sv */
// ----------------------------------------------------------------------------
// mandelbrot_escape_counter_unit
// Escape-time iteration z = z*z + c for one fixed-point point c at a time.
// ----------------------------------------------------------------------------
// A point is taken when start is high and busy is low. One signed 32x32
// multiplier is shared by the three products of each iteration, so an
// iteration steps through S_RR, S_II and S_RI for the three products, then
// S_UPD for the escape check and z update. When a point is done, busy drops
// and its word appears on the out_ ports with out_strobe for one cycle;
// a new point may be started in that same cycle. out_strobe cannot be held
// off. The user must write registers through cfg_ only while no point is
// in flight; the block itself does not enforce it.
module mandelbrot_escape_counter_unit
  import mec_pkg::*;
#(
  parameter int FRAC_BITS   = 28,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [C_W-1:0] in_c_real,
  input  logic signed [C_W-1:0] in_c_imag,
  output logic                 out_strobe,
  output logic [CNT_OUT_W-1:0] out_step_count,
  output logic                 out_limit_hit,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THR_W-1:0]     cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RR   = 3'd1;
  localparam logic [2:0] S_II   = 3'd2;
  localparam logic [2:0] S_RI   = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;

  localparam logic [32:0] CNT_MAX = (33'd1 << COUNT_WIDTH) - 33'd1;

  logic [2:0]             state_r, state_nxt;
  logic [THR_W-1:0]       thr_r;
  logic [LIM_W-1:0]       lim_cfg_r;
  cpart_t                 cr_r, ci_r, zr_r, zi_r, zr_nxt, zi_nxt;
  prod_t                  rr_r, ii_r, ri_r, diff_r;
  logic                   esc_r;
  logic [COUNT_WIDTH-1:0] n_r, n_nxt, limit_r;
  logic                   strobe_r, strobe_nxt, hit_r, hit_nxt;

  cpart_t                 mul_a, mul_b;
  prod_t                  prod;
  logic [PROD_W-1:0]      mag;
  logic                   esc_nxt;
  logic [32:0]            lim_ext;
  logic [COUNT_WIDTH-1:0] lim_eff;
  logic [31:0]            n_ext;
  logic                   accept;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // shared multiplier
  assign mul_a = (state_r == S_II) ? zi_r : zr_r;
  assign mul_b = (state_r == S_RR) ? zr_r : zi_r;
  assign prod  = mul_a * mul_b;

  assign mag     = ($unsigned(rr_r) + $unsigned(ii_r)) >> FRAC_BITS;
  assign esc_nxt = mag > PROD_W'(thr_r);

  assign lim_ext = 33'(lim_cfg_r);
  assign lim_eff = (lim_ext < CNT_MAX) ? COUNT_WIDTH'(lim_ext) : COUNT_WIDTH'(CNT_MAX);

  assign n_ext          = 32'(n_r);
  assign out_step_count = n_ext[CNT_OUT_W-1:0];
  assign out_limit_hit  = hit_r;
  assign out_strobe     = strobe_r;

  always_comb begin
    state_nxt  = state_r;
    zr_nxt     = zr_r;
    zi_nxt     = zi_r;
    n_nxt      = n_r;
    strobe_nxt = 1'b0;
    hit_nxt    = hit_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_RR;
          zr_nxt    = '0;
          zi_nxt    = '0;
          n_nxt     = '0;
        end
      end
      S_RR: state_nxt = S_II;
      S_II: state_nxt = S_RI;
      S_RI: state_nxt = S_UPD;
      S_UPD: begin
        if (esc_r) begin
          state_nxt  = S_IDLE;
          strobe_nxt = 1'b1;
          hit_nxt    = 1'b0;
        end else if (n_r >= limit_r) begin
          state_nxt  = S_IDLE;
          strobe_nxt = 1'b1;
          hit_nxt    = 1'b1;
        end else begin
          zr_nxt    = sat_c((diff_r >>> FRAC_BITS) + prod_t'(cr_r));
          zi_nxt    = sat_c((ri_r >>> (FRAC_BITS - 1)) + prod_t'(ci_r));
          n_nxt     = n_r + 1'b1;
          state_nxt = S_RR;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      strobe_r  <= 1'b0;
      thr_r     <= THR_RESET;
      lim_cfg_r <= LIM_RESET;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ESCAPE_THRESHOLD: thr_r     <= cfg_data;
          REG_ITERATION_LIMIT:  lim_cfg_r <= cfg_data[LIM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    zr_r  <= zr_nxt;
    zi_r  <= zi_nxt;
    n_r   <= n_nxt;
    hit_r <= hit_nxt;
    if (accept) begin
      cr_r    <= in_c_real;
      ci_r    <= in_c_imag;
      limit_r <= lim_eff;
    end
    if (state_r == S_RR) begin
      rr_r <= prod;
    end
    if (state_r == S_II) begin
      ii_r <= prod;
    end
    if (state_r == S_RI) begin
      ri_r   <= prod;
      esc_r  <= esc_nxt;
      diff_r <= rr_r - ii_r;
    end
  end

  a_start_goes_rr: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_RR))
    else $error("accepted point did not start iterating");

  a_strobe_from_upd: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> ($past(state_r) == S_UPD) && (state_r == S_IDLE))
    else $error("result word without finishing iteration");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |=> !strobe_r)
    else $error("result word repeated");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && state_r != S_RR) |-> (n_r <= limit_r))
    else $error("step count past limit");

  a_hit_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && hit_r) |-> (n_r == limit_r))
    else $error("limit flag without reaching limit");

endmodule

/* bench/mandelbrot_escape_counter_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_counter_unit_tb
// Checks escape counts and limit flags against an in-bench fixed-point
// iterator, over directed corner points and bursty random points under
// several threshold and limit settings.
// ----------------------------------------------------------------------------
module mandelbrot_escape_counter_unit_tb;
  import mec_pkg::*;

  localparam int FRAC_BITS   = 28;
  localparam int COUNT_WIDTH = 16;
  localparam longint CNT_MAX = (64'sd1 <<< COUNT_WIDTH) - 1;

  localparam cpart_t ONE   = 32'sd268435456;
  localparam cpart_t C_MAX = 32'sh7FFF_FFFF;
  localparam cpart_t C_MIN = 32'sh8000_0000;

  localparam logic [THR_W-1:0] THR_DEFAULT = 35'd1073741824;
  localparam logic [THR_W-1:0] THR_HIGH    = 35'd17179869184;
  localparam logic [THR_W-1:0] THR_MAX     = '1;
  localparam logic [THR_W-1:0] THR_ZERO    = '0;
  localparam logic [LIM_W-1:0] LIM_DEFAULT = 16'd255;
  localparam logic [LIM_W-1:0] LIM_MAX     = '1;
  localparam logic [LIM_W-1:0] LIM_ZERO    = '0;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

  typedef struct packed {
    logic [CNT_OUT_W-1:0] step_count;
    logic                 limit_hit;
  } escape_word_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 start      = 1'b0;
  cpart_t               c_real_drv = '0;
  cpart_t               c_imag_drv = '0;
  logic                 cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = REG_ESCAPE_THRESHOLD;
  logic [THR_W-1:0]     cfg_data   = '0;
  logic                 busy;
  logic                 out_strobe;
  logic [CNT_OUT_W-1:0] out_step_count;
  logic                 out_limit_hit;
  logic                 cfg_ready;

  logic [THR_W-1:0] thr_setting   = THR_DEFAULT;
  logic [LIM_W-1:0] limit_setting = LIM_DEFAULT;
  escape_word_t     pending_words[$];
  int               mismatches = 0;

  mandelbrot_escape_counter_unit #(
    .FRAC_BITS  (FRAC_BITS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_c_real     (c_real_drv),
    .in_c_imag     (c_imag_drv),
    .out_strobe    (out_strobe),
    .out_step_count(out_step_count),
    .out_limit_hit (out_limit_hit),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint clamp_part(input longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic escape_word_t predict_escape(input cpart_t cr, input cpart_t ci);
    longint       zr, zi, rr, ii, ri, eff_limit;
    logic [63:0]  mag;
    longint       n;
    logic         stop;
    escape_word_t w;
    zr = 0;
    zi = 0;
    n = 0;
    stop = 1'b0;
    w.limit_hit = 1'b0;
    eff_limit = (longint'(limit_setting) < CNT_MAX) ? longint'(limit_setting) : CNT_MAX;
    while (!stop) begin
      rr = zr * zr;
      ii = zi * zi;
      mag = ($unsigned(rr) + $unsigned(ii)) >> FRAC_BITS;
      if (mag > 64'(thr_setting)) begin
        stop = 1'b1;
      end else if (n >= eff_limit) begin
        w.limit_hit = 1'b1;
        stop = 1'b1;
      end else begin
        ri = zr * zi;
        zr = clamp_part(((rr - ii) >>> FRAC_BITS) + longint'(cr));
        zi = clamp_part((ri >>> (FRAC_BITS - 1)) + longint'(ci));
        n++;
      end
    end
    w.step_count = n[CNT_OUT_W-1:0];
    return w;
  endfunction

  task automatic report_mismatch(input string what, input longint want, input longint got);
    $display("ERROR %0t: %s expected %0d got %0d", $time, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_words
    escape_word_t want;
    if (rst_n && out_strobe) begin
      if (pending_words.size() == 0) begin
        report_mismatch("word with nothing pending, step_count", -1, out_step_count);
      end else begin
        want = pending_words.pop_front();
        if (out_step_count !== want.step_count)
          report_mismatch("step_count", want.step_count, out_step_count);
        if (out_limit_hit !== want.limit_hit)
          report_mismatch("limit_hit", want.limit_hit, out_limit_hit);
      end
    end
  end

  task automatic send_point(input cpart_t cr, input cpart_t ci);
    start      <= 1'b1;
    c_real_drv <= cr;
    c_imag_drv <= ci;
    do @(posedge clk); while (busy);
    pending_words.push_back(predict_escape(cr, ci));
  endtask

  task automatic all_words_in();
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_ESCAPE_THRESHOLD) begin
      thr_setting = data;
    end else if (idx == REG_ITERATION_LIMIT) begin
      limit_setting = data[LIM_W-1:0];
    end
  endtask

  task automatic set_regs(input logic [THR_W-1:0] thr, input logic [LIM_W-1:0] lim);
    logic [THR_W-1:0] lim_word;
    lim_word = THR_W'({$urandom, lim});
    all_words_in();
    reg_write(REG_ESCAPE_THRESHOLD, thr);
    reg_write(REG_ITERATION_LIMIT, lim_word);
    cfg_valid <= 1'b0;
  endtask

  function automatic cpart_t pick_between(input int lo, input int hi);
    return cpart_t'(lo + int'($urandom_range(hi - lo, 0)));
  endfunction

  function automatic cpart_t pick_edge();
    case ($urandom_range(2))
      0: return C_MAX;
      1: return C_MIN;
      default: return '0;
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_point('0, '0);
    send_point(2 * ONE, '0);
    send_point(-2 * ONE, '0);
    send_point('0, ONE);
    send_point(-ONE, '0);
    send_point(ONE / 4, '0);
    send_point(cpart_t'(32'sd69793218), '0);  // 0.26, slow escape
    send_point(C_MAX, C_MAX);
    send_point(C_MIN, C_MIN);
    send_point(C_MAX, C_MIN);
    send_point(C_MIN, C_MAX);
    send_point('0, C_MIN);
    send_point(cpart_t'(-32'sd201326592), cpart_t'(32'sd26843546));
    all_words_in();
  endtask

  task automatic test_threshold_extremes();
    set_regs(THR_MAX, 16'd20);
    send_point(C_MAX, C_MAX);  // z pinned at saturation, never escapes
    send_point(C_MIN, C_MIN);
    send_point('0, C_MAX);
    set_regs(THR_ZERO, 16'd20);
    send_point('0, '0);
    send_point(cpart_t'(32'sd1), '0);
    send_point(ONE, '0);
    all_words_in();
  endtask

  task automatic test_limit_extremes();
    set_regs(THR_DEFAULT, LIM_ZERO);
    send_point('0, '0);
    send_point(C_MAX, C_MAX);
    set_regs(THR_DEFAULT, 16'd1);
    send_point('0, '0);
    send_point(2 * ONE, '0);
    set_regs(THR_DEFAULT, LIM_MAX);
    send_point('0, '0);
    all_words_in();
  endtask

  task automatic test_unmapped_registers();
    set_regs(THR_DEFAULT, 16'd10);
    reg_write(REG_UNUSED_2, THR_W'({$urandom, $urandom}));
    reg_write(REG_UNUSED_3, THR_MAX);
    cfg_valid <= 1'b0;
    send_point('0, '0);
    all_words_in();
  endtask

  task automatic test_random_points(input int count, input logic [THR_W-1:0] thr,
                                    input logic [LIM_W-1:0] lim);
    int     burst_left;
    int     k;
    cpart_t cr, ci;
    burst_left = 0;
    set_regs(thr, lim);
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(30, 1)) @(posedge clk);
        burst_left = ($urandom_range(5) == 0) ? $urandom_range(80, 40) : $urandom_range(16, 1);
      end
      k = $urandom_range(99);
      if (k < 55) begin
        cr = pick_between(-563714458, 161061274);   // -2.1 .. 0.6
        ci = pick_between(-348966092, 348966092);   // -1.3 .. 1.3
      end else if (k < 70) begin
        cr = pick_between(-214748365, -187904819);  // -0.8 .. -0.7
        ci = pick_between(13421773, 40265318);      // 0.05 .. 0.15
      end else if (k < 85) begin
        cr = cpart_t'($urandom);
        ci = cpart_t'($urandom);
      end else if ($urandom_range(1)) begin
        cr = pick_edge();
        ci = cpart_t'($urandom);
      end else begin
        cr = cpart_t'($urandom);
        ci = pick_edge();
      end
      send_point(cr, ci);
      burst_left--;
      if (i % 250 == 249) all_words_in();
    end
    all_words_in();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_threshold_extremes();
    test_limit_extremes();
    test_unmapped_registers();
    test_random_points(400, THR_DEFAULT, LIM_DEFAULT);
    test_random_points(400, THR_DEFAULT, 16'd64);
    test_random_points(300, THR_W'($urandom_range(32'hFFFF_FFFF, 32'd33554432)), 16'd16);
    test_random_points(150, THR_MAX, 16'd8);
    test_random_points(100, THR_ZERO, 16'd12);
    test_random_points(100, THR_HIGH, 16'd1);
    test_random_points(50, THR_W'({$urandom, $urandom}), LIM_W'($urandom_range(300, 1)));
    all_words_in();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("mandelbrot_escape_counter_unit test passed");
    end else begin
      $display("mandelbrot_escape_counter_unit test failed");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("mandelbrot_escape_counter_unit test failed");
    $finish;
  end

endmodule
